FILE: sv/assert_macros.svh
// assertion macros shared by the decoder modules
// expects signals named clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every clock edge out of reset
`define LZSS_CHECK(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("lzss invariant violated");

// same-cycle implication checked at every clock edge out of reset
`define LZSS_CHECK_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzss implication violated");

`endif

FILE: sv/lzss_pkg.sv
// shared constants, command types for the lzss stream decoder
// no dependencies
`default_nettype none

package lzss_pkg;

  localparam int RING_SIZE      = 4096;
  localparam int MAX_MATCH      = 18;
  localparam int MIN_MATCH_BIAS = 2;
  localparam int RING_AW        = $clog2(RING_SIZE);
  localparam int FILL_W         = RING_AW + 1;
  localparam int BYTE_W         = 8;
  localparam int LEN_W          = $clog2(MAX_MATCH + 1);
  localparam int COUNT_W        = 31;
  localparam int CMDQ_DEPTH     = 4;

  localparam logic [RING_AW-1:0] RING_START = RING_AW'(RING_SIZE - MAX_MATCH);
  localparam logic [LEN_W-1:0]   LEN_BIAS   = LEN_W'(MIN_MATCH_BIAS + 1);
  localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(RING_SIZE);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_LIT  = 2'd1,
    CMD_COPY = 2'd2
  } cmd_op_t;

  // one unit of work for the back end
  typedef struct packed {
    logic                clr;  // new stream: reset ring window and counters
    cmd_op_t             op;
    logic [BYTE_W-1:0]   lit;
    logic [RING_AW-1:0]  src;
    logic [LEN_W-1:0]    len;
    logic                fin;  // end report follows this command's bytes
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/lzss_in_if.sv
// compressed byte channel
// depends on nothing
`default_nettype none

interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] data_byte;

  modport source (output valid, output start_req, output data_byte, input ready);
  modport sink (input valid, input start_req, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/lzss_out_if.sv
// decoded result channel
// depends on lzss_pkg for the count width
`default_nettype none

interface lzss_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  out_byte;
  logic                        kind;
  logic [lzss_pkg::COUNT_W-1:0] total_out;
  logic                        last;

  modport source (output valid, output out_byte, output kind, output total_out,
                  output last, input ready);
  modport sink (input valid, input out_byte, input kind, input total_out,
                input last, output ready);
endinterface

`default_nettype wire

FILE: sv/lzss_stream_decoder.sv
// LZSS stream decoder, 4096-byte window. Compressed bytes enter on the stream
// channel, one per request; a request with start_req high opens a new stream
// whose first four bytes are the little-endian body length. Decoded bytes
// and one end-of-stream report (kind 1, saturating total in total_out) leave
// on the result channel, one per request, with last marking the final result
// caused by each input byte. The front end takes one compressed byte per
// cycle as long as its command queue has room. The back end picks up a
// command in its idle state, then emits its decoded bytes one per cycle
// while the result channel takes them, then the end report if the command
// carries fin; the single-port-read ring and the one-byte-per-cycle output
// register set that rate. No clearing pass is needed at stream start: a
// running count of bytes written since the start makes untouched window
// entries read as zero. Depends on lzss_pkg, lzss_in_if, lzss_out_if,
// lzss_front, lzss_cmdq, lzss_back.
`default_nettype none

module lzss_stream_decoder #(
  parameter int CMDQ_DEPTH = lzss_pkg::CMDQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  lzss_in_if.sink     stream,
  lzss_out_if.source  result
);
  import lzss_pkg::*;

  // commands from parser to expander
  cmd_t push_cmd, pop_cmd;
  logic push, full, pop, empty;

  // front end: header count, flag bits, token assembly
  lzss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .stream   (stream),
    .cmd      (push_cmd),
    .cmd_push (push),
    .cmd_full (full)
  );

  // decouples parsing from byte expansion so each side stalls on its own
  lzss_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  // back end: ring window, copy engine, output register
  lzss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (pop_cmd),
    .cmd_empty (empty),
    .cmd_pop   (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

FILE: sv/lzss_ram.sv
// generic single-port-write, single-port-read ram with registered read
// depends on lzss_pkg for default sizes
`default_nettype none

module lzss_ram #(
  parameter int WIDTH = lzss_pkg::BYTE_W,
  parameter int DEPTH = lzss_pkg::RING_SIZE
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/lzss_cmdq.sv
// small command fifo between front-end parser and back-end expander
// depends on lzss_pkg
`default_nettype none
`include "assert_macros.svh"

module lzss_cmdq #(
  parameter int DEPTH = lzss_pkg::CMDQ_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lzss_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output lzss_pkg::cmd_t  pop_cmd,
  output logic            empty
);
  import lzss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push_ok, pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  `LZSS_CHECK(a_cmdq_bounded, count <= CW'(DEPTH))

endmodule

`default_nettype wire

FILE: sv/lzss_front.sv
// front end: header and flag parsing, turns input bytes into commands
// depends on lzss_pkg, lzss_in_if
`default_nettype none
`include "assert_macros.svh"

module lzss_front (
  input  logic            clk,
  input  logic            rst,
  lzss_in_if.sink         stream,
  output lzss_pkg::cmd_t  cmd,
  output logic            cmd_push,
  input  logic            cmd_full
);
  import lzss_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_FLAG   = 6'b000100,
    PH_LIT    = 6'b001000,
    PH_OFFLO  = 6'b010000,
    PH_OFFHI  = 6'b100000
  } phase_t;

  phase_t      phase, phase_next, phase_e, token_phase;
  logic [1:0]  header_index, header_index_next, hi_e;
  logic [31:0] remaining, remaining_next, rem_e;
  logic [15:0] flag_shift, flag_shift_next, fs_e, fs_sh;
  logic [7:0]  offset_low, offset_low_next;
  logic [7:0]  b;
  logic        start, fire, fin;

  assign stream.ready = !cmd_full;
  assign fire  = stream.valid && stream.ready;
  assign start = stream.start_req;
  assign b     = stream.data_byte;

  always_comb begin
    // a start request abandons whatever was in flight
    phase_e = start ? PH_HEADER : phase;
    hi_e    = start ? 2'd0 : header_index;
    rem_e   = start ? 32'd0 : remaining;
    fs_e    = start ? 16'd0 : flag_shift;

    fs_sh = {1'b0, fs_e[15:1]};
    if (!fs_sh[8]) begin
      token_phase = PH_FLAG;
    end else begin
      token_phase = fs_sh[0] ? PH_LIT : PH_OFFLO;
    end

    phase_next        = phase_e;
    header_index_next = hi_e;
    remaining_next    = rem_e;
    flag_shift_next   = fs_e;
    offset_low_next   = start ? 8'd0 : offset_low;
    fin               = 1'b0;

    cmd.clr = start;
    cmd.op  = CMD_NONE;
    cmd.lit = b;
    cmd.src = {b[7:4], offset_low};
    cmd.len = {1'b0, b[3:0]} + LEN_BIAS;
    cmd.fin = 1'b0;

    unique case (phase_e)
      PH_HEADER: begin
        remaining_next = rem_e | (32'(b) << {hi_e, 3'b000});
        if (hi_e == 2'd3) begin
          header_index_next = 2'd0;
          phase_next        = PH_FLAG;
          fin               = (remaining_next == 32'd0);
        end else begin
          header_index_next = hi_e + 2'd1;
        end
      end
      PH_FLAG, PH_LIT, PH_OFFLO, PH_OFFHI: begin
        if (rem_e == 32'd0) begin
          fin = 1'b1;
        end else begin
          remaining_next = rem_e - 32'd1;
          priority if (phase_e == PH_FLAG) begin
            flag_shift_next = {8'hff, b};
            phase_next      = b[0] ? PH_LIT : PH_OFFLO;
          end else if (phase_e == PH_LIT) begin
            cmd.op          = CMD_LIT;
            flag_shift_next = fs_sh;
            phase_next      = token_phase;
          end else if (phase_e == PH_OFFLO) begin
            offset_low_next = b;
            phase_next      = PH_OFFHI;
          end else begin
            cmd.op          = CMD_COPY;
            flag_shift_next = fs_sh;
            phase_next      = token_phase;
          end
          fin = (remaining_next == 32'd0);
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (fin) begin
      phase_next = PH_IDLE;
    end
    cmd.fin  = fin;
    cmd_push = fire && (start || (cmd.op != CMD_NONE) || fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      header_index <= '0;
      remaining    <= '0;
      flag_shift   <= '0;
      offset_low   <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      header_index <= header_index_next;
      remaining    <= remaining_next;
      flag_shift   <= flag_shift_next;
      offset_low   <= offset_low_next;
    end
  end

  `LZSS_CHECK_IMPL(a_front_push_room, cmd_push, !cmd_full)

endmodule

`default_nettype wire

FILE: sv/lzss_back.sv
// back end: expands commands into decoded bytes through the ring window
// depends on lzss_pkg, lzss_out_if, lzss_ram
`default_nettype none
`include "assert_macros.svh"

module lzss_back (
  input  logic            clk,
  input  logic            rst,
  input  lzss_pkg::cmd_t  cmd,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  lzss_out_if.source      result
);
  import lzss_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_LIT  = 4'b0010,
    B_COPY = 4'b0100,
    B_END  = 4'b1000
  } bstate_t;

  bstate_t             state, state_next;
  logic [RING_AW-1:0]  wp, wp_next;
  logic [FILL_W-1:0]   fill, fill_next;
  logic [COUNT_W-1:0]  out_count, out_count_next;
  logic [BYTE_W-1:0]   lit, lit_next;
  logic [RING_AW-1:0]  src_ptr, src_ptr_next;
  logic [LEN_W-1:0]    left, left_next;
  logic                fin, fin_next;
  logic                byp, byp_next, rd_zero, rd_zero_next;
  logic [BYTE_W-1:0]   byp_data, byp_data_next;

  logic                ovalid, ovalid_next;
  logic [BYTE_W-1:0]   o_byte, o_byte_next;
  logic                o_kind, o_kind_next, o_last, o_last_next;
  logic [COUNT_W-1:0]  o_total, o_total_next;

  logic                ram_we, ram_re;
  logic [RING_AW-1:0]  ram_raddr, rd_dist;
  logic [BYTE_W-1:0]   ram_rdata, copy_byte, emit_byte;
  logic                slot_free, emit, emit_kind, emit_last;

  lzss_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_SIZE)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (emit_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_free = !ovalid || result.ready;
  // entries not yet written in this stream read as zero
  assign copy_byte = byp ? byp_data : (rd_zero ? '0 : ram_rdata);
  assign rd_dist   = ram_raddr - RING_START;

  always_comb begin
    state_next     = state;
    wp_next        = wp;
    fill_next      = fill;
    out_count_next = out_count;
    lit_next       = lit;
    src_ptr_next   = src_ptr;
    left_next      = left;
    fin_next       = fin;
    cmd_pop        = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = src_ptr;
    emit           = 1'b0;
    emit_kind      = 1'b0;
    emit_last      = 1'b0;
    emit_byte      = lit;

    unique case (state)
      B_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop  = 1'b1;
          fin_next = cmd.fin;
          lit_next = cmd.lit;
          if (cmd.clr) begin
            wp_next        = RING_START;
            fill_next      = '0;
            out_count_next = '0;
          end
          unique case (cmd.op)
            CMD_LIT: begin
              state_next = B_LIT;
            end
            CMD_COPY: begin
              ram_re       = 1'b1;
              ram_raddr    = cmd.src;
              src_ptr_next = cmd.src + 1'b1;
              left_next    = cmd.len;
              state_next   = B_COPY;
            end
            CMD_NONE: begin
              if (cmd.fin) begin
                state_next = B_END;
              end
            end
            default: begin
              state_next = B_IDLE;
            end
          endcase
        end
      end
      B_LIT: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_byte  = lit;
          emit_last  = !fin;
          state_next = fin ? B_END : B_IDLE;
        end
      end
      B_COPY: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = copy_byte;
          emit_last = (left == LEN_W'(1)) && !fin;
          if (left != LEN_W'(1)) begin
            ram_re       = 1'b1;
            src_ptr_next = src_ptr + 1'b1;
            left_next    = left - 1'b1;
          end else begin
            state_next = fin ? B_END : B_IDLE;
          end
        end
      end
      B_END: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = 1'b1;
          emit_byte  = '0;
          emit_last  = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase

    // every decoded byte lands in the ring
    ram_we = emit && !emit_kind;
    if (ram_we) begin
      wp_next        = wp + 1'b1;
      fill_next      = (fill == FILL_FULL) ? fill : fill + 1'b1;
      out_count_next = (out_count == COUNT_MAX) ? out_count : out_count + 1'b1;
    end

    // forward a byte written in the same cycle it is read
    byp_next      = byp;
    byp_data_next = byp_data;
    rd_zero_next  = rd_zero;
    if (ram_re) begin
      byp_next      = ram_we && (ram_raddr == wp);
      byp_data_next = emit_byte;
      rd_zero_next  = !({1'b0, rd_dist} < fill);
    end

    ovalid_next  = ovalid && !result.ready;
    o_byte_next  = o_byte;
    o_kind_next  = o_kind;
    o_last_next  = o_last;
    o_total_next = o_total;
    if (emit) begin
      ovalid_next  = 1'b1;
      o_byte_next  = emit_byte;
      o_kind_next  = emit_kind;
      o_last_next  = emit_last;
      o_total_next = emit_kind ? out_count : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      wp        <= RING_START;
      fill      <= '0;
      out_count <= '0;
      ovalid    <= 1'b0;
      fin       <= 1'b0;
      left      <= '0;
    end else begin
      state     <= state_next;
      wp        <= wp_next;
      fill      <= fill_next;
      out_count <= out_count_next;
      ovalid    <= ovalid_next;
      fin       <= fin_next;
      left      <= left_next;
    end
  end

  always_ff @(posedge clk) begin
    lit      <= lit_next;
    src_ptr  <= src_ptr_next;
    byp      <= byp_next;
    byp_data <= byp_data_next;
    rd_zero  <= rd_zero_next;
    o_byte   <= o_byte_next;
    o_kind   <= o_kind_next;
    o_last   <= o_last_next;
    o_total  <= o_total_next;
  end

  assign result.valid     = ovalid;
  assign result.out_byte  = o_byte;
  assign result.kind      = o_kind;
  assign result.total_out = o_total;
  assign result.last      = o_last;

  `LZSS_CHECK_IMPL(a_back_write_has_slot, ram_we, slot_free)
  `LZSS_CHECK(a_back_fill_bounded, fill <= FILL_FULL)

endmodule

`default_nettype wire

FILE: sim/tb_lzss_stream_decoder.sv
// self-checking testbench for lzss_stream_decoder: compressed streams in, decoded bytes out
// predicts every result with its own decoder model and checks it against the result channel
// depends on lzss_pkg, lzss_in_if, lzss_out_if and the decoder rtl
module tb_lzss_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import lzss_pkg::*;

  // cycles with no request on either channel before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // quiet cycles after the last expected result, to catch stray results
  localparam int TAIL_CYCLES = 40;

  // decoder state as seen by the prediction
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEADER,
    ST_FLAGS,
    ST_LITERAL,
    ST_OFFSET_LO,
    ST_OFFSET_HI
  } dec_state_t;

  // ways a generated stream can be shaped
  typedef enum logic [1:0] {
    SHAPE_WHOLE,       // count matches the body exactly
    SHAPE_SHORT_COUNT, // count runs out early, possibly inside a token
    SHAPE_CUT_OFF,     // body abandoned by the next stream start
    SHAPE_HUGE_COUNT   // count never runs out
  } stream_shape_t;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } request_t;

  typedef struct packed {
    logic [7:0]         value;
    logic               kind;
    logic [COUNT_W-1:0] total;
    logic               last;
  } decoded_t;

  logic clk = 1'b0;
  logic rst;

  lzss_in_if  stream_ch ();
  lzss_out_if result_ch ();

  lzss_stream_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .result (result_ch)
  );

  // compressed bytes waiting to be sent, front entry is the one on the bus
  request_t pending_q[$];
  // decoded results still owed by the block, oldest first
  decoded_t expected_q[$];

  // request accepted at the last rising edge, predicted at the falling edge
  logic     handed = 1'b0;
  request_t handed_item;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int quiet_cycles   = 0;

  // prediction state
  logic [7:0]         window [RING_SIZE];
  logic [RING_AW-1:0] win_wr;
  logic [15:0]        flag_bits;
  dec_state_t         dstate;
  logic [1:0]         hdr_idx;
  logic [31:0]        body_left;
  logic [7:0]         off_lo;
  logic [COUNT_W-1:0] decoded_cnt;

  initial begin
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------

  // a new stream wipes the window and every counter
  function automatic void open_stream();
    for (int i = 0; i < RING_SIZE; i++) window[i] = 8'h00;
    win_wr      = RING_START;
    flag_bits   = '0;
    dstate      = ST_HEADER;
    hdr_idx     = '0;
    body_left   = '0;
    off_lo      = '0;
    decoded_cnt = '0;
  endfunction

  // one decoded byte: owed as a result and written back to the window
  function automatic void emit_byte(logic [7:0] v);
    expected_q.push_back('{value: v, kind: 1'b0, total: '0, last: 1'b0});
    window[win_wr] = v;
    win_wr++;
    if (decoded_cnt != COUNT_MAX) decoded_cnt++;
  endfunction

  // shift to the next flag bit, or ask for a fresh flag byte once all 8 are used
  function automatic void next_token();
    flag_bits = flag_bits >> 1;
    if (!flag_bits[8]) dstate = ST_FLAGS;
    else dstate = flag_bits[0] ? ST_LITERAL : ST_OFFSET_LO;
  endfunction

  function automatic void decode_byte(logic start, logic [7:0] b);
    logic               finish;
    logic [RING_AW-1:0] src;
    logic [RING_AW-1:0] rd;
    int                 len;
    int                 base;
    decoded_t           tail;
    finish = 1'b0;
    base   = expected_q.size();
    if (start) open_stream();
    case (dstate)
      ST_HEADER: begin
        // little-endian body length
        body_left[hdr_idx*8 +: 8] = b;
        if (hdr_idx == 2'd3) begin
          hdr_idx = '0;
          dstate  = ST_FLAGS;
          finish  = (body_left == 0);
        end else begin
          hdr_idx++;
        end
      end
      ST_FLAGS, ST_LITERAL, ST_OFFSET_LO, ST_OFFSET_HI: begin
        if (body_left == 0) begin
          finish = 1'b1;
        end else begin
          body_left--;
          case (dstate)
            ST_FLAGS: begin
              flag_bits = {8'hff, b};
              dstate    = b[0] ? ST_LITERAL : ST_OFFSET_LO;
            end
            ST_LITERAL: begin
              emit_byte(b);
              next_token();
            end
            ST_OFFSET_LO: begin
              off_lo = b;
              dstate = ST_OFFSET_HI;
            end
            default: begin
              // copy may read bytes it wrote itself
              src = {b[7:4], off_lo};
              len = int'(b[3:0]) + MIN_MATCH_BIAS + 1;
              for (int k = 0; k < len; k++) begin
                rd = src + RING_AW'(k);
                emit_byte(window[rd]);
              end
              next_token();
            end
          endcase
          // count used up: report even if a pair was cut in half
          if (body_left == 0) finish = 1'b1;
        end
      end
      // idle bytes without a start are dropped
      default: dstate = ST_IDLE;
    endcase
    if (finish) begin
      expected_q.push_back('{value: 8'h00, kind: 1'b1, total: decoded_cnt, last: 1'b0});
      dstate = ST_IDLE;
    end
    if (expected_q.size() > base) begin
      tail      = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
  endfunction

  always @(negedge clk) begin
    if (handed) decode_byte(handed_item.start, handed_item.data);
  end

  // ------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------

  function automatic void queue_request(logic start, logic [7:0] data);
    pending_q.push_back('{start: start, data: data});
  endfunction

  // builds a random body of literals and pairs, returns the number of requests queued
  function automatic int add_stream(int tokens, stream_shape_t shape);
    logic [7:0]         body[$];
    logic [7:0]         flag;
    logic [RING_AW-1:0] src;
    logic [3:0]         len_code;
    logic [31:0]        count;
    int                 made;
    int                 t;
    int                 sent;
    int                 back_dist;
    made = 0;
    t    = 0;
    while (t < tokens) begin
      flag = 8'($urandom);
      body.push_back(flag);
      for (int i = 0; i < 8 && t < tokens; i++) begin
        if (flag[i]) begin
          body.push_back(8'($urandom));
          made++;
        end else begin
          len_code = 4'($urandom);
          // half the pairs point just behind the write position, often overlapping
          if (made > 0 && $urandom_range(1) == 1) begin
            back_dist = $urandom_range(made < 40 ? made : 40, 1);
            src       = RING_START + RING_AW'(made - back_dist);
          end else begin
            src = RING_AW'($urandom);
          end
          body.push_back(src[7:0]);
          body.push_back({src[11:8], len_code});
          made += int'(len_code) + 3;
        end
        t++;
      end
    end
    count = body.size();
    sent  = body.size();
    case (shape)
      SHAPE_SHORT_COUNT: count = $urandom_range(body.size() - 1, 1);
      SHAPE_CUT_OFF:     sent  = $urandom_range(body.size() - 1, 0);
      SHAPE_HUGE_COUNT:  count = 32'hffff_ffff - $urandom_range(255);
      default: ;
    endcase
    for (int i = 0; i < 4; i++) queue_request(i == 0, count[i*8 +: 8]);
    for (int i = 0; i < sent; i++) queue_request(1'b0, body[i]);
    return 4 + sent;
  endfunction

  // mostly well-formed streams, the rest broken ones and stray bytes
  function automatic void fill_random(int goal);
    int got;
    int pick;
    got = 0;
    while (got < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        got += add_stream($urandom_range(12, 1), SHAPE_WHOLE);
        // block is idle now, so these bytes must vanish
        if ($urandom_range(4) == 0) begin
          for (int i = $urandom_range(3, 1); i > 0; i--) queue_request(1'b0, 8'($urandom));
        end
      end else if (pick < 80) begin
        got += add_stream($urandom_range(8, 1), SHAPE_SHORT_COUNT);
      end else if (pick < 90) begin
        got += add_stream($urandom_range(8, 1), SHAPE_CUT_OFF);
      end else begin
        got += add_stream($urandom_range(4, 1), SHAPE_HUGE_COUNT);
        // noise decoded as body until the next start abandons it
        for (int i = $urandom_range(6); i > 0; i--) begin
          queue_request(1'b0, 8'($urandom));
          got++;
        end
      end
    end
  endfunction

  // ------------------------------------------------------------------
  // driver: one request at a time from pending_q, valid held until taken
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    logic take;
    logic go;
    if (rst) begin
      stream_ch.valid     <= 1'b0;
      stream_ch.start_req <= 1'b0;
      stream_ch.data_byte <= 8'h00;
      handed              <= 1'b0;
    end else begin
      take = stream_ch.valid && stream_ch.ready;
      handed      <= take;
      handed_item <= {stream_ch.start_req, stream_ch.data_byte};
      if (take) void'(pending_q.pop_front());
      go = (stream_ch.valid && !take) ||
           (pending_q.size() > 0 && $urandom_range(99) >= send_gap_pct);
      stream_ch.valid <= go;
      if (go) begin
        stream_ch.start_req <= pending_q[0].start;
        stream_ch.data_byte <= pending_q[0].data;
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: every result request is checked against the oldest expectation
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = '{value: result_ch.out_byte, kind: result_ch.kind,
                total: result_ch.total_out, last: result_ch.last};
        if (expected_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result byte %h kind %0d total %0d last %0d",
                   $time, got.value, got.kind, got.total, got.last);
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value || got.kind !== want.kind ||
              got.total !== want.total || got.last !== want.last) begin
            err_count++;
            $display("%0t: result mismatch, expected byte %h kind %0d total %0d last %0d",
                     $time, want.value, want.kind, want.total, want.last);
            $display("%0t:                    got byte %h kind %0d total %0d last %0d",
                     $time, got.value, got.kind, got.total, got.last);
          end
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: a long stretch with no request on either side means a hang
  always @(posedge clk) begin
    if (rst || (stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    rst                 = 1'b1;
    stream_ch.valid     = 1'b0;
    stream_ch.start_req = 1'b0;
    stream_ch.data_byte = 8'h00;
    result_ch.ready     = 1'b0;
    open_stream();
    dstate = ST_IDLE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // three idling phases: receiver-heavy stalls, sender-heavy gaps, then full speed
    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct   = (ph == 0) ? 32 : (ph == 1) ? 50 : 0;
      recv_stall_pct = (ph == 0) ? 50 : (ph == 1) ? 32 : 0;
      if (ph == 0) begin
        // stray byte while idle: no result
        queue_request(1'b0, 8'h5a);
        // zero count: report right on the last header byte
        queue_request(1'b1, 8'h00);
        queue_request(1'b0, 8'h00);
        queue_request(1'b0, 8'h00);
        queue_request(1'b0, 8'h00);
        // count 6: literal ff, overlapping 18-byte copy, literal 00, pair cut after its low byte
        queue_request(1'b1, 8'h06);
        queue_request(1'b0, 8'h00);
        queue_request(1'b0, 8'h00);
        queue_request(1'b0, 8'h00);
        queue_request(1'b0, 8'h05);
        queue_request(1'b0, 8'hff);
        queue_request(1'b0, 8'hee);
        queue_request(1'b0, 8'hff);
        queue_request(1'b0, 8'h00);
        queue_request(1'b0, 8'h12);
        // restart in the middle of a header, new stream ends on its flag byte
        queue_request(1'b1, 8'h10);
        queue_request(1'b0, 8'h00);
        queue_request(1'b1, 8'h01);
        queue_request(1'b0, 8'h00);
        queue_request(1'b0, 8'h00);
        queue_request(1'b0, 8'h00);
        queue_request(1'b0, 8'h00);
      end
      fill_random(70);
      // sender holds off until the block has delivered everything
      while (pending_q.size() != 0 || stream_ch.valid || handed || expected_q.size() != 0)
        @(negedge clk);
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
